### sv/ifec_pkg.sv
// Shared constants, types and helpers of the IMU / force EMA conditioner.
// No dependencies; every other file imports this package.
package ifec_pkg;

    localparam int NUM_AXES            = 6;
    localparam int ALPHA_W             = 9;
    localparam int ALPHA_FRAC          = 8;
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;

    localparam int DEF_SAMPLE_WIDTH    = 16;
    localparam int DEF_ADC_WIDTH       = 12;
    localparam int DEF_FRAC_BITS       = 8;

    localparam logic [ALPHA_W-1:0] IMU_ALPHA_RST   = 9'd51;
    localparam logic [ALPHA_W-1:0] FORCE_ALPHA_RST = 9'd26;
    localparam int BASELINE_RST        = 0;
    localparam int GATE_RST            = 300;

    localparam int CFG_IDX_W           = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMU_ALPHA      = 2'd0,
        CFG_FORCE_ALPHA    = 2'd1,
        CFG_FORCE_BASELINE = 2'd2,
        CFG_GATE_THRESHOLD = 2'd3
    } t_cfg_idx;

    function automatic logic [ALPHA_W-1:0] clamp_alpha(input logic [ALPHA_W-1:0] a);
        return (a > ALPHA_ONE) ? ALPHA_ONE : a;
    endfunction

endpackage

### sv/ifec_ema_lane.sv
// One exponential moving average lane: state register, load on first item,
// alpha-weighted update otherwise. Depends on ifec_pkg.
module ifec_ema_lane #(
    parameter int XW        = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_first,
    input  logic [ifec_pkg::ALPHA_W-1:0]        i_alpha,
    input  logic signed [XW-1:0]                i_x,
    output logic signed [XW-1:0]                o_int
);
    import ifec_pkg::*;

    localparam int SW = XW + FRAC_BITS;
    localparam int DW = SW + 1;
    localparam int PW = DW + ALPHA_W + 1;

    logic signed [SW-1:0] r_state, n_state;
    logic signed [DW-1:0] w_target, w_diff;
    logic signed [PW-1:0] w_prod, w_step, w_sum;

    always_comb begin
        w_target = $signed({i_x[XW-1], i_x, {FRAC_BITS{1'b0}}});
        w_diff   = w_target - DW'(r_state);
        w_prod   = PW'($signed({1'b0, i_alpha})) * PW'(w_diff);
        w_step   = w_prod >>> ALPHA_FRAC;
        w_sum    = PW'(r_state) + w_step;
        if (i_first) begin
            n_state = $signed({i_x, {FRAC_BITS{1'b0}}});
        end else begin
            n_state = w_sum[SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_int = r_state[SW-1:FRAC_BITS];

endmodule

### sv/imu_force_ema_conditioner_unit.sv
// Top level of the IMU / force EMA conditioner: stream ports, configuration
// registers, input register and seven filter lanes. Depends on ifec_pkg, ifec_ema_lane.
// Result path: input register loaded at the accepting edge, then filter state register, which
// is also the result register, loaded when the item advances through the output handshake.
// Throughput: one item per cycle; the stall path is the result register handshake.
// Reset: clears valids and filter states, sets the first-item flag, loads register defaults.
module imu_force_ema_conditioner_unit #(
    parameter int SAMPLE_WIDTH = ifec_pkg::DEF_SAMPLE_WIDTH,
    parameter int ADC_WIDTH    = ifec_pkg::DEF_ADC_WIDTH,
    parameter int FRAC_BITS    = ifec_pkg::DEF_FRAC_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // acc_x, acc_y, acc_z, gyro_x, gyro_y, gyro_z, force_sample, zero fill
    input  logic [((ifec_pkg::NUM_AXES*SAMPLE_WIDTH+ADC_WIDTH+7)/8)*8-1:0] i_s_tdata,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // smooth_acc_x .. smooth_gyro_z, gated_force, zero fill
    output logic [((ifec_pkg::NUM_AXES*SAMPLE_WIDTH+ADC_WIDTH+7)/8)*8-1:0] o_m_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic                                i_cfg_we,
    input  logic [ifec_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [((ADC_WIDTH > ifec_pkg::ALPHA_W) ? ADC_WIDTH : ifec_pkg::ALPHA_W)-1:0]
                                                i_cfg_data
);
    import ifec_pkg::*;

    localparam int FW = ADC_WIDTH + 1;

    logic [ALPHA_W-1:0]   r_imu_alpha, r_force_alpha;
    logic [ADC_WIDTH-1:0] r_baseline, r_gate;

    logic                           r_in_vld, r_out_vld, r_first;
    logic signed [SAMPLE_WIDTH-1:0] r_axis [NUM_AXES];
    logic [ADC_WIDTH-1:0]           r_force, n_force;
    logic [ADC_WIDTH-1:0]           w_fs;
    logic                           w_out_free, w_adv, w_accept;
    logic signed [SAMPLE_WIDTH-1:0] w_axis_int [NUM_AXES];
    logic signed [FW-1:0]           w_force_int;
    logic [ADC_WIDTH-1:0]           w_gated;
    logic [ALPHA_W-1:0]             w_imu_a, w_force_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imu_alpha   <= IMU_ALPHA_RST;
            r_force_alpha <= FORCE_ALPHA_RST;
            r_baseline    <= ADC_WIDTH'(BASELINE_RST);
            r_gate        <= ADC_WIDTH'(GATE_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_IMU_ALPHA:      r_imu_alpha   <= i_cfg_data[ALPHA_W-1:0];
                CFG_FORCE_ALPHA:    r_force_alpha <= i_cfg_data[ALPHA_W-1:0];
                CFG_FORCE_BASELINE: r_baseline    <= i_cfg_data[ADC_WIDTH-1:0];
                CFG_GATE_THRESHOLD: r_gate        <= i_cfg_data[ADC_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_adv      = r_in_vld && w_out_free;
    assign o_s_tready = !r_in_vld || w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_imu_a    = clamp_alpha(r_imu_alpha);
    assign w_force_a  = clamp_alpha(r_force_alpha);

    always_comb begin
        w_fs    = i_s_tdata[NUM_AXES*SAMPLE_WIDTH +: ADC_WIDTH];
        n_force = (w_fs > r_baseline) ? (w_fs - r_baseline) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_first   <= 1'b1;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_first   <= 1'b0;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            for (int i = 0; i < NUM_AXES; i++) begin
                r_axis[i] <= $signed(i_s_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH]);
            end
            r_force <= n_force;
        end
    end

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        ifec_ema_lane #(
            .XW        (SAMPLE_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_adv),
            .i_first (r_first),
            .i_alpha (w_imu_a),
            .i_x     (r_axis[g]),
            .o_int   (w_axis_int[g])
        );
    end

    ifec_ema_lane #(
        .XW        (FW),
        .FRAC_BITS (FRAC_BITS)
    ) u_force_lane (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_first (r_first),
        .i_alpha (w_force_a),
        .i_x     ($signed({1'b0, r_force})),
        .o_int   (w_force_int)
    );

    always_comb begin
        w_gated   = (w_force_int[ADC_WIDTH-1:0] < r_gate) ? '0 : w_force_int[ADC_WIDTH-1:0];
        o_m_tdata = '0;
        for (int i = 0; i < NUM_AXES; i++) begin
            o_m_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH] = w_axis_int[i];
        end
        o_m_tdata[NUM_AXES*SAMPLE_WIDTH +: ADC_WIDTH] = w_gated;
    end

    assign o_m_tvalid = r_out_vld;

    a_first_clears_on_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> $past(w_adv))
        else $error("first-item flag cleared without a state update");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> o_s_tready)
        else $error("input stalled with an empty result register");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && r_out_vld && !i_m_tready |-> !o_s_tready)
        else $error("item accepted while both stages are held");

    a_gate_passes_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_gated != '0 |-> w_gated == w_force_int[ADC_WIDTH-1:0])
        else $error("gated force differs from filtered force");

    a_force_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !w_force_int[FW-1])
        else $error("force filter state went negative");

endmodule

### tb/imu_force_ema_conditioner_unit_tb.sv
// Self-checking testbench of the IMU / force EMA conditioner: drives sample sets over the
// input stream, predicts each filtered result and compares it with the output stream.
// Depends on ifec_pkg and imu_force_ema_conditioner_unit.
module imu_force_ema_conditioner_unit_tb;
    import ifec_pkg::*;

    localparam int SW = DEF_SAMPLE_WIDTH;
    localparam int AW = DEF_ADC_WIDTH;
    localparam int FB = DEF_FRAC_BITS;
    localparam int DW = ((NUM_AXES * SW + AW + 7) / 8) * 8;
    localparam int CW = (AW > ALPHA_W) ? AW : ALPHA_W;
    localparam int HOLD_CYCLES = 90;

    typedef struct {
        logic signed [SW-1:0] axis [NUM_AXES];
        logic [AW-1:0]        force_raw;
    } imu_sample_t;

    typedef struct {
        logic signed [SW-1:0] axis [NUM_AXES];
        logic [AW-1:0]        gated_force;
    } smooth_out_t;

    class ema_scoreboard;
        logic [ALPHA_W-1:0] imu_alpha;
        logic [ALPHA_W-1:0] force_alpha;
        logic [AW-1:0]      baseline;
        logic [AW-1:0]      threshold;
        longint             axis_state [NUM_AXES];
        longint             force_state;
        bit                 first_pending;
        smooth_out_t        expected_q [$];
        int                 errors;
        int                 n_checked;
        string axis_name [NUM_AXES] = '{"smooth_acc_x", "smooth_acc_y", "smooth_acc_z",
                                        "smooth_gyro_x", "smooth_gyro_y", "smooth_gyro_z"};

        function new();
            imu_alpha     = IMU_ALPHA_RST;
            force_alpha   = FORCE_ALPHA_RST;
            baseline      = AW'(BASELINE_RST);
            threshold     = AW'(GATE_RST);
            foreach (axis_state[k]) axis_state[k] = 0;
            force_state   = 0;
            first_pending = 1'b1;
            errors        = 0;
            n_checked     = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [CW-1:0] v);
            case (idx)
                CFG_IMU_ALPHA:      imu_alpha   = v[ALPHA_W-1:0];
                CFG_FORCE_ALPHA:    force_alpha = v[ALPHA_W-1:0];
                CFG_FORCE_BASELINE: baseline    = v[AW-1:0];
                CFG_GATE_THRESHOLD: threshold   = v[AW-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint ema_update(longint st, longint x, longint a);
            return st + ((a * ((x <<< FB) - st)) >>> ALPHA_FRAC);
        endfunction

        function void note_sample(imu_sample_t s);
            longint a_imu;
            longint a_frc;
            longint corr;
            longint fint;
            smooth_out_t e;
            a_imu = (imu_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(imu_alpha);
            a_frc = (force_alpha > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(force_alpha);
            corr  = (s.force_raw > baseline) ? longint'(s.force_raw) - longint'(baseline) : 0;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (first_pending) begin
                    axis_state[k] = longint'(s.axis[k]) <<< FB;
                end else begin
                    axis_state[k] = ema_update(axis_state[k], longint'(s.axis[k]), a_imu);
                end
                e.axis[k] = SW'(axis_state[k] >>> FB);
            end
            if (first_pending) begin
                force_state = corr <<< FB;
            end else begin
                force_state = ema_update(force_state, corr, a_frc);
            end
            first_pending = 1'b0;
            fint = force_state >>> FB;
            if (fint < 0 || fint < longint'(threshold)) begin
                fint = 0;
            end
            e.gated_force = AW'(fint);
            expected_q.push_back(e);
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 20) begin
                $display("MISMATCH at %0t: %s", $time, msg);
            end
        endtask

        task check_result(smooth_out_t r);
            smooth_out_t e;
            if (expected_q.size() == 0) begin
                report("result with no sample set waiting");
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            for (int k = 0; k < NUM_AXES; k++) begin
                if (r.axis[k] !== e.axis[k]) begin
                    report($sformatf("%s got %0d want %0d", axis_name[k], r.axis[k], e.axis[k]));
                end
            end
            if (r.gated_force !== e.gated_force) begin
                report($sformatf("gated_force got %0d want %0d", r.gated_force, e.gated_force));
            end
        endtask
    endclass

    logic          clk = 1'b0;
    logic          rst_n;
    logic [DW-1:0] s_tdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [DW-1:0] m_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic          cfg_we;
    t_cfg_idx      cfg_idx;
    logic [CW-1:0] cfg_data;

    ema_scoreboard        sb;
    bit                   idle_on = 1'b1;
    bit                   hold_req = 1'b0;
    int                   n_holds = 0;
    int                   n_settings = 0;
    logic signed [SW-1:0] drift [NUM_AXES];

    imu_force_ema_conditioner_unit i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [DW-1:0] pack_sample(imu_sample_t s);
        logic [DW-1:0] d;
        d = '0;
        for (int k = 0; k < NUM_AXES; k++) d[k*SW +: SW] = s.axis[k];
        d[NUM_AXES*SW +: AW] = s.force_raw;
        return d;
    endfunction

    function automatic smooth_out_t unpack_result(logic [DW-1:0] d);
        smooth_out_t r;
        for (int k = 0; k < NUM_AXES; k++) r.axis[k] = d[k*SW +: SW];
        r.gated_force = d[NUM_AXES*SW +: AW];
        return r;
    endfunction

    function automatic imu_sample_t uniform_sample(logic signed [SW-1:0] v, logic [AW-1:0] f);
        imu_sample_t s;
        for (int k = 0; k < NUM_AXES; k++) s.axis[k] = v;
        s.force_raw = f;
        return s;
    endfunction

    function automatic logic signed [SW-1:0] extreme_axis();
        case ($urandom_range(0, 4))
            0: return {1'b1, {(SW-1){1'b0}}};
            1: return {1'b0, {(SW-1){1'b1}}};
            2: return '0;
            3: return '1;
            default: return SW'(1);
        endcase
    endfunction

    // style 0: full random, 1: extremes, 2: slow random walk around a drifting center
    function automatic imu_sample_t make_sample(int style, logic [AW-1:0] base);
        imu_sample_t s;
        int f;
        for (int k = 0; k < NUM_AXES; k++) begin
            case (style)
                0: s.axis[k] = SW'($urandom);
                1: s.axis[k] = extreme_axis();
                default: begin
                    drift[k] = drift[k] + SW'(int'($urandom_range(0, 2000)) - 1000);
                    s.axis[k] = drift[k] + SW'(int'($urandom_range(0, 64)) - 32);
                end
            endcase
        end
        case ($urandom_range(0, 3))
            0: f = int'($urandom_range(0, (1 << AW) - 1));
            1: f = ($urandom_range(0, 1) == 1) ? (1 << AW) - 1 : 0;
            default: f = int'(base) + int'($urandom_range(0, 600)) - 100;
        endcase
        if (f < 0) f = 0;
        if (f > (1 << AW) - 1) f = (1 << AW) - 1;
        s.force_raw = AW'(f);
        return s;
    endfunction

    task automatic send_sample(imu_sample_t s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_sample(s);
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_sample(s);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CW-1:0] v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic [CW-1:0] a_imu, logic [CW-1:0] a_frc,
                             logic [CW-1:0] base, logic [CW-1:0] thr,
                             int n_items, bit with_hold);
        write_reg(CFG_IMU_ALPHA, a_imu);
        write_reg(CFG_FORCE_ALPHA, a_frc);
        write_reg(CFG_FORCE_BASELINE, base);
        write_reg(CFG_GATE_THRESHOLD, thr);
        cfg_we <= 1'b0;
        n_settings++;
        for (int n = 0; n < n_items; n++) begin
            if (with_hold && n == n_items / 3) hold_req = 1'b1;
            send_sample(make_sample(int'($urandom_range(0, 2)), base[AW-1:0]));
        end
        drain();
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial begin
        m_tready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                n_holds++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat (idle_on ? $urandom_range(1, 16) : 1) @(posedge clk);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(unpack_result(m_tdata));
    end

    initial begin
        #4_000_000;
        $display("[imu_force_ema_conditioner_unit] ERROR");
        $finish;
    end

    initial begin
        sb = new();
        foreach (drift[k]) drift[k] = '0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        cfg_we   <= 1'b0;
        cfg_idx  <= CFG_IMU_ALPHA;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first item loads the filters directly, then extremes under reset settings
        send_sample(uniform_sample(16'sh7fff, 12'hfff));
        send_sample(uniform_sample(16'sh8000, 12'h000));
        send_sample(uniform_sample(16'sh0000, 12'hfff));
        send_sample(uniform_sample(-16'sd1, 12'd1));
        send_sample(uniform_sample(16'sd1, 12'd299));
        send_sample(uniform_sample(16'sh7fff, 12'd300));
        repeat (8) send_sample(uniform_sample(16'sh7fff, 12'hfff));
        repeat (4) send_sample(uniform_sample(16'sh8000, 12'h000));
        drain();

        run_phase(CW'(51), CW'(26), CW'(0), CW'(300), 160, 1'b1);
        run_phase(CW'(256), CW'(256), CW'(0), CW'(0), 150, 1'b0);
        run_phase(CW'(0), CW'(0), CW'(4095), CW'(4095), 100, 1'b0);
        run_phase(CW'(511), CW'(300), CW'(2048), CW'(100), 150, 1'b0);
        run_phase(CW'(1), CW'(1), CW'(0), CW'(4095), 120, 1'b0);
        run_phase(12'he80, 12'h3c8, CW'(1000), CW'(50), 120, 1'b0);
        repeat (4) begin
            run_phase(CW'($urandom_range(0, 511)), CW'($urandom_range(0, 511)),
                      CW'($urandom_range(0, 4095)), CW'($urandom_range(0, 4095)), 100, 1'b0);
        end
        idle_on = 1'b0;
        run_phase(CW'($urandom_range(0, 256)), CW'($urandom_range(0, 256)),
                  CW'($urandom_range(0, 2000)), CW'($urandom_range(0, 1000)), 150, 1'b0);
        repeat (10) @(posedge clk);

        $display("checked %0d sample sets over %0d register settings, alphas 0 to 511",
                 sb.n_checked, n_settings);
        $display("long output hold-offs: %0d, with random gaps on both stream sides", n_holds);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("[imu_force_ema_conditioner_unit] OK");
        end else begin
            $display("[imu_force_ema_conditioner_unit] ERROR");
        end
        $finish;
    end
endmodule
